FILE: hw/rtl/aip_pkg.sv
// Shared types, constants and codes of the ASCII integer parser.
package aip_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_CHARS_DEF   = 4096;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [5:0] BASE_RESET = 6'd10;
  localparam logic [5:0] MAX_BASE   = 6'd36;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_BIN   = 6'd2;
  localparam logic [5:0] BASE_AUTO  = 6'd0;
  localparam logic [5:0] BASE_BAD   = 6'd1;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] CASE_BIT   = 8'h20;   // 'a' ^ 'A'
  localparam logic [6:0] NO_DIGIT   = 7'd99;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_BAD_BASE = 2'd2;

  // One classified byte as it travels from the front end to the back end.
  typedef struct packed {
    logic [6:0] digit;
    logic       space;
    logic       plus;
    logic       minus;
    logic       zero;
    logic       letter_x;
    logic       letter_b;
    logic       last;
    logic       first;
    logic       beyond;
    logic [5:0] base;
  } aip_class_t;

endpackage

FILE: hw/rtl/aip_ifs.sv
// Channel interfaces: character input, configuration write and result output.
interface aip_char_if;
  import aip_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;
  modport source (output valid, char_code, last, input ready);
  modport sink (input valid, char_code, last, output ready);
endinterface

interface aip_cfg_if;
  import aip_pkg::*;
  logic       valid;
  logic       ready;
  logic [5:0] base_mode;
  modport source (output valid, base_mode, input ready);
  modport sink (input valid, base_mode, output ready);
endinterface

interface aip_result_if #(
  parameter int VALUE_WIDTH  = aip_pkg::VALUE_WIDTH_DEF,
  parameter int OFFSET_WIDTH = $clog2(aip_pkg::MAX_CHARS_DEF + 1)
);
  import aip_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [OFFSET_WIDTH-1:0]       end_offset;
  logic [1:0]                    status;
  modport source (output valid, value, end_offset, status, input ready);
  modport sink (input valid, value, end_offset, status, output ready);
endinterface

FILE: hw/rtl/aip_front.sv
// Front end: base register, byte index counter and byte classification.
module aip_front #(
  parameter int MAX_CHARS = aip_pkg::MAX_CHARS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  aip_char_if.sink             chars,
  aip_cfg_if.sink              cfg,
  output logic                 push_valid,
  input  logic                 push_ready,
  output aip_pkg::aip_class_t  push_class,
  output logic [$clog2(MAX_CHARS+1)-1:0] push_idx
);
  import aip_pkg::*;

  localparam int IW = $clog2(MAX_CHARS + 1);

  logic [5:0]    base_mode;
  logic [IW-1:0] idx;
  logic          accept;
  logic          beyond;

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'(c - ASCII_UPPER_A) & ~CASE_BIT;
      if (c[7]) digit_of = NO_DIGIT;
      else if (c >= ASCII_UPPER_A) digit_of = 7'(t) + 7'(BASE_DEC);
      else if (c >= ASCII_ZERO && c <= ASCII_NINE) digit_of = 7'(c - ASCII_ZERO);
      else digit_of = NO_DIGIT;
    end
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode <= BASE_RESET;
    end else if (cfg.valid) begin
      base_mode <= cfg.base_mode;
    end
  end

  assign accept = chars.valid && chars.ready;
  assign beyond = (idx == IW'(MAX_CHARS));

  // index of the next byte; saturates at the string limit
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      if (chars.last) idx <= '0;
      else if (!beyond) idx <= idx + 1'b1;
    end
  end

  assign chars.ready = push_ready;
  assign push_valid  = chars.valid;
  assign push_idx    = idx;

  always_comb begin
    push_class.digit    = digit_of(chars.char_code);
    push_class.space    = (chars.char_code == 8'h20) ||
                          (chars.char_code >= 8'h09 && chars.char_code <= 8'h0D);
    push_class.plus     = (chars.char_code == 8'h2B);
    push_class.minus    = (chars.char_code == 8'h2D);
    push_class.zero     = (chars.char_code == ASCII_ZERO);
    push_class.letter_x = ((chars.char_code | CASE_BIT) == 8'h78);
    push_class.letter_b = ((chars.char_code | CASE_BIT) == 8'h62);
    push_class.last     = chars.last;
    push_class.first    = (idx == '0);
    push_class.beyond   = beyond;
    push_class.base     = base_mode;
  end

endmodule

FILE: hw/rtl/aip_queue.sv
// Small register FIFO between the front end and the back end.
module aip_queue #(
  parameter int W     = 8,
  parameter int DEPTH = aip_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  import aip_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/aip_back.sv
// Back end: parse state machine, saturating accumulate and result register.
module aip_back #(
  parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_CHARS   = aip_pkg::MAX_CHARS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  aip_pkg::aip_class_t  pop_class,
  input  logic [$clog2(MAX_CHARS+1)-1:0] pop_idx,
  aip_result_if.source         results
);
  import aip_pkg::*;

  localparam int IW = $clog2(MAX_CHARS + 1);
  localparam int VW = VALUE_WIDTH;
  localparam int PW = VW + 7;

  localparam logic [2:0] PH_SPACE   = 3'd0;
  localparam logic [2:0] PH_SIGNED  = 3'd1;
  localparam logic [2:0] PH_ZERO    = 3'd2;
  localparam logic [2:0] PH_PREFIX  = 3'd3;
  localparam logic [2:0] PH_DIGITS  = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;
  localparam logic [2:0] PH_INVALID = 3'd6;

  logic [2:0]    phase,       phase_next;
  logic          negative,    negative_next;
  logic [5:0]    active_base, base_next;
  logic [VW-1:0] magnitude,   magnitude_next;
  logic          overflowed,  overflowed_next;
  logic [IW-1:0] stop_index,  stop_next;

  logic          out_valid;
  logic [VW-1:0] out_value,   value_next;
  logic [IW-1:0] out_offset;
  logic [1:0]    out_status,  status_next;

  logic          pop;
  logic          take;
  logic          after_sign;
  logic [PW-1:0] prod;
  logic [PW-1:0] lim;

  assign pop_ready = !pop_class.last || !out_valid || results.ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    base_next       = active_base;
    magnitude_next  = magnitude;
    overflowed_next = overflowed;
    stop_next       = stop_index;
    take            = 1'b0;
    after_sign      = 1'b0;
    prod            = '0;
    lim             = '0;

    // base is sampled on the first byte of each string
    if (pop_class.first) begin
      base_next = pop_class.base;
      if (pop_class.base == BASE_BAD || pop_class.base > MAX_BASE) phase_next = PH_INVALID;
    end

    if (pop_class.beyond) begin
      if (phase_next != PH_INVALID) phase_next = PH_DONE;
    end else begin
      unique case (phase_next)
        PH_SPACE: begin
          if (pop_class.space) begin
            phase_next = PH_SPACE;
          end else if (pop_class.plus) begin
            phase_next = PH_SIGNED;
          end else if (pop_class.minus) begin
            negative_next = 1'b1;
            phase_next    = PH_SIGNED;
          end else begin
            after_sign = 1'b1;
          end
        end
        PH_SIGNED: after_sign = 1'b1;
        PH_ZERO: begin
          if ((base_next == BASE_HEX || base_next == BASE_AUTO) && pop_class.letter_x) begin
            base_next  = BASE_HEX;
            phase_next = PH_PREFIX;
          end else if ((base_next == BASE_BIN || base_next == BASE_AUTO) &&
                       pop_class.letter_b) begin
            base_next  = BASE_BIN;
            phase_next = PH_PREFIX;
          end else begin
            if (base_next == BASE_AUTO) base_next = BASE_OCT;
            take = 1'b1;
          end
        end
        PH_PREFIX, PH_DIGITS: take = 1'b1;
        default: phase_next = phase_next;
      endcase

      if (after_sign) begin
        if (pop_class.zero) begin
          stop_next  = pop_idx + 1'b1;
          phase_next = PH_ZERO;
        end else begin
          if (base_next == BASE_AUTO) base_next = BASE_DEC;
          take = 1'b1;
        end
      end

      if (take) begin
        if (base_next < BASE_BIN || pop_class.digit >= 7'(base_next)) begin
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_DIGITS;
          stop_next  = pop_idx + 1'b1;
          // magnitude*base + d > limit is the overflow test
          prod = PW'(magnitude) * PW'(base_next) + PW'(pop_class.digit);
          lim  = (PW'(1) << (VW - 1)) - PW'(!negative_next);
          if (!overflowed) begin
            if (prod > lim) overflowed_next = 1'b1;
            else magnitude_next = prod[VW-1:0];
          end
        end
      end
    end

    if (phase_next == PH_INVALID) begin
      value_next  = '0;
      status_next = ST_BAD_BASE;
    end else if (overflowed_next) begin
      value_next  = negative_next ? (VW'(1) << (VW - 1)) : ~(VW'(1) << (VW - 1));
      status_next = ST_OVERFLOW;
    end else begin
      value_next  = negative_next ? VW'(-magnitude_next) : magnitude_next;
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SPACE;
      negative    <= 1'b0;
      active_base <= '0;
      magnitude   <= '0;
      overflowed  <= 1'b0;
      stop_index  <= '0;
    end else if (pop) begin
      if (pop_class.last) begin
        phase       <= PH_SPACE;
        negative    <= 1'b0;
        active_base <= '0;
        magnitude   <= '0;
        overflowed  <= 1'b0;
        stop_index  <= '0;
      end else begin
        phase       <= phase_next;
        negative    <= negative_next;
        active_base <= base_next;
        magnitude   <= magnitude_next;
        overflowed  <= overflowed_next;
        stop_index  <= stop_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && pop_class.last) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_class.last) begin
      out_value  <= value_next;
      out_offset <= (phase_next == PH_INVALID) ? '0 : stop_next;
      out_status <= status_next;
    end
  end

  assign results.valid      = out_valid;
  assign results.value      = out_value;
  assign results.end_offset = out_offset;
  assign results.status     = out_status;

endmodule

FILE: hw/rtl/ascii_integer_parser_top.sv
// Streaming strtol: one ASCII byte per request in, one signed value per string out.
// Takes one byte per clock cycle while results are taken. While a result waits on the
// output the block keeps taking bytes until the next byte marked last reaches the back
// end; that byte then waits there, the two-entry queue fills and the byte input stalls.
// The rate is set by the back end's combinational multiply-accumulate and limit compare;
// the byte marked last passes the queue, and the result is registered when the back end
// takes it. The base register is sampled on the first byte of each string, so a write
// applies to the next string. A byte at index MAX_CHARS or later stops the parse.
module ascii_integer_parser_top #(
  parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_CHARS   = aip_pkg::MAX_CHARS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  aip_char_if.sink      chars,
  aip_cfg_if.sink       cfg,
  aip_result_if.source  results
);
  import aip_pkg::*;

  localparam int IW = $clog2(MAX_CHARS + 1);
  localparam int CW = $bits(aip_class_t);
  localparam int QW = IW + CW;

  logic          push_valid;
  logic          push_ready;
  aip_class_t    push_class;
  logic [IW-1:0] push_idx;
  logic          pop_valid;
  logic          pop_ready;
  logic [QW-1:0] pop_data;
  aip_class_t    pop_class;
  logic [IW-1:0] pop_idx;

  aip_front #(.MAX_CHARS(MAX_CHARS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_class (push_class),
    .push_idx   (push_idx)
  );

  aip_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_idx, push_class}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_class = aip_class_t'(pop_data[CW-1:0]);
  assign pop_idx   = pop_data[QW-1:CW];

  aip_back #(.VALUE_WIDTH(VALUE_WIDTH), .MAX_CHARS(MAX_CHARS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_class (pop_class),
    .pop_idx   (pop_idx),
    .results   (results)
  );

endmodule

FILE: tb/sv/ascii_integer_parser_top_tb.sv
// Self-checking testbench for the streaming ASCII integer parser, with a cycle-free predictor.
`timescale 1ns / 100ps

module ascii_integer_parser_top_tb;
  import aip_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 40;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_X     = "x";
  localparam logic [7:0] CH_B     = "b";

  localparam logic [5:0] BASE_SWEEP [14] = '{BASE_DEC, BASE_AUTO, BASE_HEX, BASE_BIN, MAX_BASE,
                                              BASE_OCT, 6'd7, BASE_AUTO, BASE_BAD, 6'd37,
                                              6'd63, 6'd3, 6'd35, BASE_DEC};

  typedef enum logic [2:0] {
    SCAN_SPACE, SCAN_SIGNED, SCAN_ZERO, SCAN_PREFIX, SCAN_DIGITS, SCAN_DONE, SCAN_INVALID
  } scan_phase_e;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [12:0]        end_offset;
    logic [1:0]         status;
  } parse_result_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       ch_valid = 1'b0;
  logic [7:0] ch_code  = '0;
  logic       ch_last  = 1'b0;
  logic       cf_valid = 1'b0;
  logic [5:0] cf_base  = '0;
  logic       rs_ready = 1'b0;

  aip_char_if   chars_if();
  aip_cfg_if    cfg_if();
  aip_result_if results_if();

  assign chars_if.valid     = ch_valid;
  assign chars_if.char_code = ch_code;
  assign chars_if.last      = ch_last;
  assign cfg_if.valid       = cf_valid;
  assign cfg_if.base_mode   = cf_base;
  assign results_if.ready   = rs_ready;

  ascii_integer_parser_top uut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .cfg     (cfg_if),
    .results (results_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Handshake flags sampled at the rising edge, read by the falling-edge drivers.
  logic char_taken = 1'b0;
  logic cfg_taken  = 1'b0;
  logic res_taken  = 1'b0;

  char_item_t    pending_chars[$];
  parse_result_t expected_results[$];

  int tx_gap_max = 0;
  int rx_gap_max = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  bit pressure_go = 1'b0;
  logic rx_hold = 1'b0;

  int strings_queued = 0;
  int results_seen = 0;
  int bytes_accepted = 0;
  int mismatch_count = 0;
  int sat_count = 0;
  int bad_base_count = 0;
  int input_stalls = 0;
  int base_writes = 0;
  int quiet_cycles = 0;

  // Predictor state
  logic [5:0]  cfg_base = BASE_RESET;
  scan_phase_e scan = SCAN_SPACE;
  logic        is_neg = 1'b0;
  logic [5:0]  cur_base = '0;
  logic [63:0] mag = '0;
  logic        ovf = 1'b0;
  logic [12:0] char_pos = '0;
  logic [12:0] stop_at = '0;

  function automatic void clear_string();
    scan     = SCAN_SPACE;
    is_neg   = 1'b0;
    cur_base = '0;
    mag      = '0;
    ovf      = 1'b0;
    char_pos = '0;
    stop_at  = '0;
  endfunction

  function automatic logic [6:0] digit_value(input logic [7:0] c);
    if (c >= 8'h80) return NO_DIGIT;
    if (c >= ASCII_UPPER_A)
      return 7'(((int'(c) - int'(ASCII_UPPER_A)) & ~int'(CASE_BIT)) + 10);
    if (c >= ASCII_ZERO && c <= ASCII_NINE) return 7'(c - ASCII_ZERO);
    return NO_DIGIT;
  endfunction

  function automatic void take_digit(input logic [7:0] c, input logic [12:0] pos);
    logic [6:0]  d;
    logic [63:0] lim;
    d = digit_value(c);
    if (cur_base < BASE_BIN || d >= 7'(cur_base)) begin
      scan = SCAN_DONE;
      return;
    end
    scan = SCAN_DIGITS;
    stop_at = pos + 13'd1;
    if (ovf) return;
    lim = is_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (mag > (lim - 64'(d)) / 64'(cur_base)) begin
      ovf = 1'b1;
      return;
    end
    mag = mag * 64'(cur_base) + 64'(d);
  endfunction

  function automatic void after_sign(input logic [7:0] c, input logic [12:0] pos);
    if (c == ASCII_ZERO) begin
      stop_at = pos + 13'd1;
      scan = SCAN_ZERO;
      return;
    end
    if (cur_base == BASE_AUTO) cur_base = BASE_DEC;
    take_digit(c, pos);
  endfunction

  function automatic void parse_byte(input logic [7:0] c, input logic [12:0] pos);
    case (scan)
      SCAN_SPACE: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
        if (c == CH_PLUS) begin
          scan = SCAN_SIGNED;
          return;
        end
        if (c == CH_MINUS) begin
          is_neg = 1'b1;
          scan = SCAN_SIGNED;
          return;
        end
        after_sign(c, pos);
      end
      SCAN_SIGNED: after_sign(c, pos);
      SCAN_ZERO: begin
        // prefix letters are case-insensitive
        if ((cur_base == BASE_HEX || cur_base == BASE_AUTO) && (c | CASE_BIT) == CH_X) begin
          cur_base = BASE_HEX;
          scan = SCAN_PREFIX;
          return;
        end
        if ((cur_base == BASE_BIN || cur_base == BASE_AUTO) && (c | CASE_BIT) == CH_B) begin
          cur_base = BASE_BIN;
          scan = SCAN_PREFIX;
          return;
        end
        if (cur_base == BASE_AUTO) cur_base = BASE_OCT;
        take_digit(c, pos);
      end
      SCAN_PREFIX, SCAN_DIGITS: take_digit(c, pos);
      default: ;
    endcase
  endfunction

  function automatic bit predict_byte(input logic [7:0] c, input logic lst,
                                      output parse_result_t r);
    r = '0;
    if (scan == SCAN_SPACE && char_pos == 13'd0) begin
      cur_base = cfg_base;
      if (cur_base == BASE_BAD || cur_base > MAX_BASE) scan = SCAN_INVALID;
    end
    if (char_pos >= 13'(MAX_CHARS_DEF)) begin
      if (scan != SCAN_INVALID) scan = SCAN_DONE;
    end else begin
      parse_byte(c, char_pos);
      char_pos = char_pos + 13'd1;
    end
    if (!lst) return 1'b0;
    if (scan == SCAN_INVALID) begin
      r.status = ST_BAD_BASE;
    end else begin
      if (ovf) begin
        r.value  = is_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        r.status = ST_OVERFLOW;
      end else begin
        r.value  = is_neg ? -mag[31:0] : mag[31:0];
        r.status = ST_OK;
      end
      r.end_offset = stop_at;
    end
    clear_string();
    return 1'b1;
  endfunction

  function automatic int draw_gap(input int max_gap);
    if (max_gap == 0 || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, max_gap);
  endfunction

  function automatic void queue_string(input byte_q_t s);
    char_item_t it;
    foreach (s[k]) begin
      it.code = s[k];
      it.last = (k == s.size() - 1);
      pending_chars.push_back(it);
    end
    strings_queued++;
  endfunction

  function automatic void queue_text(input string txt);
    byte_q_t s;
    for (int k = 0; k < txt.len(); k++) s.push_back(txt[k]);
    queue_string(s);
  endfunction

  // Mostly well-formed numbers with random content; some pure noise and broken prefixes.
  function automatic void queue_random_string(input logic [5:0] base_sel);
    byte_q_t s;
    int radix;
    int ndig;
    int pick;
    bit auto_mode;
    auto_mode = (base_sel == BASE_AUTO);
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        pick = $urandom_range(8, 13);
        s.push_back(pick == 8 ? CH_SPACE : 8'(pick));
      end
      pick = $urandom_range(0, 3);
      if (pick == 1) s.push_back(CH_PLUS);
      else if (pick == 2) s.push_back(CH_MINUS);
      radix = (auto_mode || base_sel == BASE_BAD || base_sel > MAX_BASE) ? 10 : int'(base_sel);
      pick = $urandom_range(0, 7);
      if (pick < 2 && (auto_mode || base_sel == BASE_HEX)) begin
        s.push_back(ASCII_ZERO);
        s.push_back(CH_X ^ (pick == 0 ? CASE_BIT : 8'h00));
        radix = 16;
      end else if ((pick == 2 || pick == 3) && (auto_mode || base_sel == BASE_BIN)) begin
        s.push_back(ASCII_ZERO);
        s.push_back(CH_B ^ (pick == 2 ? CASE_BIT : 8'h00));
        radix = 2;
      end else if (pick == 4) begin
        s.push_back(ASCII_ZERO);
        if (auto_mode) radix = 8;
      end else if (pick == 5) begin
        // prefix letter the base may reject
        s.push_back(ASCII_ZERO);
        s.push_back(($urandom_range(0, 1) != 0 ? CH_X : CH_B) ^
                    ($urandom_range(0, 1) != 0 ? CASE_BIT : 8'h00));
      end
      ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 10);
      repeat (ndig) begin
        pick = $urandom_range(0, radix - 1);
        if (pick < 10) s.push_back(ASCII_ZERO + 8'(pick));
        else s.push_back((ASCII_UPPER_A + 8'(pick - 10)) |
                         ($urandom_range(0, 1) != 0 ? CASE_BIT : 8'h00));
      end
      if ($urandom_range(0, 1) != 0)
        repeat ($urandom_range(1, 2)) s.push_back(8'($urandom_range(0, 255)));
    end
    if (s.size() == 0) s.push_back(ASCII_ZERO);
    queue_string(s);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Byte sender
  always @(negedge clk) begin : char_source
    char_item_t it;
    if (rst) begin
      ch_valid <= 1'b0;
    end else if (!ch_valid || char_taken) begin
      if (tx_wait > 0) begin
        ch_valid <= 1'b0;
        tx_wait--;
      end else if (pending_chars.size() != 0) begin
        it = pending_chars.pop_front();
        ch_code  <= it.code;
        ch_last  <= it.last;
        ch_valid <= 1'b1;
        tx_wait = draw_gap(tx_gap_max);
      end else begin
        ch_valid <= 1'b0;
      end
    end
  end

  // Result receiver
  always @(negedge clk) begin : result_sink
    if (rst) begin
      rs_ready <= 1'b0;
    end else begin
      if (res_taken) rx_wait = draw_gap(rx_gap_max);
      if (rx_hold) begin
        rs_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rs_ready <= 1'b0;
        rx_wait--;
      end else begin
        rs_ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the parser fills up and stalls the byte input
  initial begin : rx_holdoff
    wait (pressure_go);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin : monitor
    parse_result_t want;
    if (rst) begin
      char_taken <= 1'b0;
      cfg_taken  <= 1'b0;
      res_taken  <= 1'b0;
      cfg_base = BASE_RESET;
      clear_string();
    end else begin
      char_taken <= chars_if.valid && chars_if.ready;
      cfg_taken  <= cfg_if.valid && cfg_if.ready;
      res_taken  <= results_if.valid && results_if.ready;
      if (chars_if.valid && !chars_if.ready) input_stalls++;
      if (cfg_if.valid && cfg_if.ready) cfg_base = cfg_if.base_mode;
      if (chars_if.valid && chars_if.ready) begin
        bytes_accepted++;
        if (predict_byte(chars_if.char_code, chars_if.last, want))
          expected_results.push_back(want);
      end
      if (results_if.valid && results_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unrequested result value", longint'(results_if.value), 0);
        end else begin
          want = expected_results.pop_front();
          if (results_if.value !== want.value)
            report_mismatch("value", longint'(results_if.value), longint'(want.value));
          if (results_if.end_offset !== want.end_offset)
            report_mismatch("end_offset", longint'(results_if.end_offset),
                            longint'(want.end_offset));
          if (results_if.status !== want.status)
            report_mismatch("status", longint'(results_if.status), longint'(want.status));
          if (want.status == ST_OVERFLOW) sat_count++;
          if (want.status == ST_BAD_BASE) bad_base_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (chars_if.valid && chars_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (results_if.valid && results_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_base(input logic [5:0] b);
    @(negedge clk);
    cf_base  <= b;
    cf_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cf_valid <= 1'b0;
    base_writes++;
  endtask

  // Every queued string ends in a last byte, so all results in means all bytes taken.
  task automatic drain();
    while (results_seen != strings_queued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    byte_q_t bq;
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset base (decimal)
    tx_gap_max = 13;
    rx_gap_max = 13;
    queue_text("\t+7");
    queue_text("-0");
    bq = {8'hFF};
    queue_string(bq);
    bq = {8'h00};
    queue_string(bq);
    drain();

    write_base(BASE_AUTO);
    queue_text("0x1f");
    queue_text("0bz");
    queue_text("017");
    queue_text("0B1");
    queue_text("9");
    drain();

    write_base(BASE_BAD);
    queue_text("5");
    drain();

    // Random strings over a sweep of base settings and idling styles
    for (int i = 0; i < 14; i++) begin
      write_base(BASE_SWEEP[i]);
      tx_gap_max = (i % 4 == 0 || i % 4 == 2) ? 13 : 0;
      rx_gap_max = (i % 4 == 0 || i % 4 == 3) ? 13 : 0;
      if (BASE_SWEEP[i] == BASE_DEC) begin
        queue_text("2147483647");
        queue_text("-2147483648");
        queue_text("2147483648");
        queue_text("-2147483649");
      end
      if (BASE_SWEEP[i] == BASE_AUTO) begin
        queue_text("0x7fffffff");
        queue_text("-0X80000000");
        queue_text("0x80000000");
        queue_text("-017777777777");
      end
      n = (BASE_SWEEP[i] == BASE_BAD || BASE_SWEEP[i] > MAX_BASE) ? 4 : 11;
      repeat (n) queue_random_string(BASE_SWEEP[i]);
      drain();
    end

    // Back-to-back strings against a stalled result side
    tx_gap_max = 0;
    rx_gap_max = 0;
    pressure_go = 1'b1;
    repeat (40) queue_random_string(BASE_DEC);
    drain();

    $display("Checked %0d strings (%0d bytes) over %0d base settings: %0d saturated, %0d bad base.",
             results_seen, bytes_accepted, base_writes + 1, sat_count, bad_base_count);
    $display("Byte input was held off for %0d cycles by result-side backpressure.",
             input_stalls);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/aip_pkg.sv
hw/rtl/aip_ifs.sv
hw/rtl/aip_front.sv
hw/rtl/aip_queue.sv
hw/rtl/aip_back.sv
hw/rtl/ascii_integer_parser_top.sv
tb/sv/ascii_integer_parser_top_tb.sv
